/* hw/rtl/skfb_pkg.sv */
package skfb_pkg;

	localparam int CH_W = 2;
	localparam int DATA_W = 32;
	localparam int GAIN_W = 16;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_STEPS = 17;
	localparam int DIV_CNT_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 1'b1;

	localparam logic [DATA_W-1:0] PROCESS_NOISE_RST = 32'd1311;
	localparam logic [DATA_W-1:0] MEASURE_NOISE_RST = 32'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIOR,
		ST_DIVS,
		ST_DIVW,
		ST_MULE,
		ST_ESTU,
		ST_COVU,
		ST_WB
	} state_t;

	typedef struct packed {
		logic ld_prior;
		logic div_start;
		logic ld_gain;
		logic mul_cov;
		logic ld_prod;
		logic ld_est;
		logic ld_cov;
		logic wb;
	} ctl_t;

	typedef struct packed {
		logic start;
		logic [DATA_W-1:0] num;
		logic [DATA_W:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [GAIN_W-1:0] quot;
	} div_rsp_t;

endpackage

/* hw/rtl/skfb_in_if.sv */
interface skfb_in_if;
	logic valid;
	logic ready;
	logic [skfb_pkg::CH_W-1:0] channel;
	logic signed [skfb_pkg::DATA_W-1:0] sample;

	modport source(output valid, output channel, output sample, input ready);
	modport sink(input valid, input channel, input sample, output ready);
endinterface

/* hw/rtl/skfb_out_if.sv */
interface skfb_out_if;
	logic valid;
	logic ready;
	logic [skfb_pkg::CH_W-1:0] channel_out;
	logic signed [skfb_pkg::DATA_W-1:0] estimate;

	modport source(output valid, output channel_out, output estimate, input ready);
	modport sink(input valid, input channel_out, input estimate, output ready);
endinterface

/* hw/rtl/skfb_cfg_if.sv */
interface skfb_cfg_if;
	logic valid;
	logic ready;
	logic [skfb_pkg::CFG_IDX_W-1:0] index;
	logic [skfb_pkg::DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

/* hw/rtl/skfb_div.sv */
module skfb_div (
	input  logic clk,
	input  logic arst_n,
	input  skfb_pkg::div_req_t req,
	output skfb_pkg::div_rsp_t rsp
);

	logic run_q;
	logic done_q;
	logic [skfb_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [skfb_pkg::DATA_W+1:0] rem_q;
	logic [skfb_pkg::DATA_W:0] dvs_q;
	logic [skfb_pkg::GAIN_W:0] quo_q;
	logic zero_q;

	logic first;
	logic [skfb_pkg::DATA_W+1:0] trial;
	logic [skfb_pkg::DATA_W+2:0] diff;
	logic ge;

	assign first = (cnt_q == skfb_pkg::DIV_CNT_W'(skfb_pkg::DIV_STEPS));
	assign trial = first ? rem_q : {rem_q[skfb_pkg::DATA_W:0], 1'b0};
	assign diff = {1'b0, trial} - {2'b00, dvs_q};
	assign ge = !diff[skfb_pkg::DATA_W+2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= skfb_pkg::DIV_CNT_W'(skfb_pkg::DIV_STEPS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == skfb_pkg::DIV_CNT_W'(1)) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= {2'b00, req.num};
			dvs_q <= req.den;
			zero_q <= (req.den == '0);
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[skfb_pkg::DATA_W+1:0] : trial;
			quo_q <= {quo_q[skfb_pkg::GAIN_W-1:0], ge};
		end
	end

	always_comb begin
		rsp.done = done_q;
		if (zero_q) begin
			rsp.quot = '0;
		end else if (quo_q[skfb_pkg::GAIN_W]) begin
			rsp.quot = '1;
		end else begin
			rsp.quot = quo_q[skfb_pkg::GAIN_W-1:0];
		end
	end

endmodule

/* hw/rtl/scalar_kalman_filter_bank_unit.sv */
// Bank of scalar Kalman filters, one estimate and one error covariance per channel.
// The samples channel takes a channel index and a signed Q16.16 sample. For each
// transaction on it, exactly one transaction appears on the results channel with
// the same channel index and the updated estimate, saturated to 32 bits.
// The cfg channel writes the process noise (index 0) and the measurement noise
// (index 1), both unsigned Q16.16. It is always ready; write it only while idle.
// An in-range item passes through the 17-step restoring divider that forms the gain;
// one shared multiplier then forms the estimate correction and the new covariance.
// The block takes the next item only once the previous one has been written back.
// A channel index at or beyond CHANNELS changes no state, goes straight to
// write-back and returns a zero estimate; the next item is taken after that.
// Reset clears every estimate and covariance and loads the noise registers
// with their defaults (Q = 1311, R = 65536).
// The result sits in an output register. A stalled receiver holds it there; the
// next item may still be accepted and runs up to its write-back, where it waits
// until the output register is free.
module scalar_kalman_filter_bank_unit #(
	parameter int CHANNELS = 3
) (
	input logic clk,
	input logic arst_n,
	skfb_in_if.sink samples,
	skfb_out_if.source results,
	skfb_cfg_if.sink cfg
);

	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	skfb_pkg::state_t state_q;
	skfb_pkg::state_t state_d;
	skfb_pkg::ctl_t ctl;

	logic [skfb_pkg::DATA_W-1:0] pnoise_q;
	logic [skfb_pkg::DATA_W-1:0] mnoise_q;

	logic signed [skfb_pkg::DATA_W-1:0] est_store_q [CHANNELS];
	logic [skfb_pkg::DATA_W-1:0] cov_store_q [CHANNELS];

	logic [skfb_pkg::CH_W-1:0] ch_q;
	logic [CH_IDX_W-1:0] idx_q;
	logic ch_ok_q;
	logic signed [skfb_pkg::DATA_W-1:0] sample_q;
	logic [skfb_pkg::DATA_W-1:0] prior_q;
	logic [skfb_pkg::DATA_W:0] den_q;
	logic signed [skfb_pkg::DATA_W:0] innov_q;
	logic [skfb_pkg::GAIN_W-1:0] gain_q;
	logic signed [51:0] prod_q;
	logic signed [skfb_pkg::DATA_W-1:0] est_next_q;
	logic [skfb_pkg::DATA_W-1:0] cov_next_q;

	logic out_valid_q;
	logic [skfb_pkg::CH_W-1:0] out_ch_q;
	logic signed [skfb_pkg::DATA_W-1:0] out_est_q;

	logic in_fire;
	logic wb_fire;
	logic [2:0] ch_ext;
	logic in_ok;
	logic signed [skfb_pkg::DATA_W-1:0] est_cur;
	logic [skfb_pkg::DATA_W-1:0] cov_cur;
	logic [skfb_pkg::DATA_W:0] prior_sum;
	logic [skfb_pkg::DATA_W-1:0] prior_d;
	logic [skfb_pkg::DATA_W:0] den_d;
	logic signed [skfb_pkg::DATA_W:0] innov_d;
	logic [skfb_pkg::GAIN_W:0] mul_a;
	logic signed [skfb_pkg::DATA_W+1:0] mul_b;
	logic signed [51:0] prod;
	logic signed [36:0] est_sum;
	logic signed [skfb_pkg::DATA_W-1:0] est_sat;

	skfb_pkg::div_req_t div_req;
	skfb_pkg::div_rsp_t div_rsp;

	assign samples.ready = (state_q == skfb_pkg::ST_IDLE);
	assign in_fire = samples.valid && samples.ready;
	assign wb_fire = ctl.wb && (!out_valid_q || results.ready);
	assign cfg.ready = 1'b1;

	assign ch_ext = {1'b0, samples.channel};
	assign in_ok = (32'(samples.channel) < CHANNELS);

	assign results.valid = out_valid_q;
	assign results.channel_out = out_ch_q;
	assign results.estimate = out_est_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnoise_q <= skfb_pkg::PROCESS_NOISE_RST;
			mnoise_q <= skfb_pkg::MEASURE_NOISE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				skfb_pkg::CFG_PROCESS_NOISE: pnoise_q <= cfg.data;
				skfb_pkg::CFG_MEASURE_NOISE: mnoise_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skfb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			skfb_pkg::ST_IDLE: begin
				if (in_fire) begin
					state_d = in_ok ? skfb_pkg::ST_PRIOR : skfb_pkg::ST_WB;
				end
			end
			skfb_pkg::ST_PRIOR: state_d = skfb_pkg::ST_DIVS;
			skfb_pkg::ST_DIVS: state_d = skfb_pkg::ST_DIVW;
			skfb_pkg::ST_DIVW: begin
				if (div_rsp.done) begin
					state_d = skfb_pkg::ST_MULE;
				end
			end
			skfb_pkg::ST_MULE: state_d = skfb_pkg::ST_ESTU;
			skfb_pkg::ST_ESTU: state_d = skfb_pkg::ST_COVU;
			skfb_pkg::ST_COVU: state_d = skfb_pkg::ST_WB;
			skfb_pkg::ST_WB: begin
				if (wb_fire) begin
					state_d = skfb_pkg::ST_IDLE;
				end
			end
			default: state_d = skfb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			skfb_pkg::ST_PRIOR: ctl.ld_prior = 1'b1;
			skfb_pkg::ST_DIVS: ctl.div_start = 1'b1;
			skfb_pkg::ST_DIVW: ctl.ld_gain = div_rsp.done;
			skfb_pkg::ST_MULE: ctl.ld_prod = 1'b1;
			skfb_pkg::ST_ESTU: begin
				ctl.ld_est = 1'b1;
				ctl.mul_cov = 1'b1;
				ctl.ld_prod = 1'b1;
			end
			skfb_pkg::ST_COVU: ctl.ld_cov = 1'b1;
			skfb_pkg::ST_WB: ctl.wb = 1'b1;
			default: ctl = '0;
		endcase
	end

	assign est_cur = est_store_q[idx_q];
	assign cov_cur = cov_store_q[idx_q];

	assign prior_sum = {1'b0, cov_cur} + {1'b0, pnoise_q};
	assign prior_d = prior_sum[skfb_pkg::DATA_W] ? '1 : prior_sum[skfb_pkg::DATA_W-1:0];
	assign den_d = {1'b0, prior_d} + {1'b0, mnoise_q};
	assign innov_d = {sample_q[skfb_pkg::DATA_W-1], sample_q}
		- {est_cur[skfb_pkg::DATA_W-1], est_cur};

	assign div_req.start = ctl.div_start;
	assign div_req.num = prior_q;
	assign div_req.den = den_q;

	skfb_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign mul_a = ctl.mul_cov ? (17'h10000 - {1'b0, gain_q}) : {1'b0, gain_q};
	assign mul_b = ctl.mul_cov ? $signed({2'b00, prior_q})
		: $signed({innov_q[skfb_pkg::DATA_W], innov_q});
	assign prod = $signed({1'b0, mul_a}) * mul_b;

	assign est_sum = {{5{est_cur[skfb_pkg::DATA_W-1]}}, est_cur}
		+ {prod_q[51], prod_q[51:16]};

	always_comb begin
		if (est_sum[36:31] == 6'b000000 || est_sum[36:31] == 6'b111111) begin
			est_sat = est_sum[31:0];
		end else if (est_sum[36]) begin
			est_sat = 32'sh80000000;
		end else begin
			est_sat = 32'sh7FFFFFFF;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q <= samples.channel;
			idx_q <= ch_ext[CH_IDX_W-1:0];
			ch_ok_q <= in_ok;
			sample_q <= samples.sample;
			est_next_q <= '0;
		end
		if (ctl.ld_prior) begin
			prior_q <= prior_d;
			den_q <= den_d;
			innov_q <= innov_d;
		end
		if (ctl.ld_gain) begin
			gain_q <= div_rsp.quot;
		end
		if (ctl.ld_prod) begin
			prod_q <= prod;
		end
		if (ctl.ld_est) begin
			est_next_q <= est_sat;
		end
		if (ctl.ld_cov) begin
			cov_next_q <= prod_q[47:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				est_store_q[i] <= '0;
				cov_store_q[i] <= '0;
			end
		end else if (wb_fire && ch_ok_q) begin
			est_store_q[idx_q] <= est_next_q;
			cov_store_q[idx_q] <= cov_next_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_fire) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) begin
			out_ch_q <= ch_q;
			out_est_q <= est_next_q;
		end
	end

`ifndef SYNTHESIS
	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == skfb_pkg::ST_DIVW)
		else $error("Divider finished outside of its wait state.");

	a_cov_not_growing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skfb_pkg::ST_WB && ch_ok_q) |-> cov_next_q <= prior_q)
		else $error("Updated covariance exceeds the prior covariance.");

	a_bad_channel_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == skfb_pkg::ST_WB && !ch_ok_q) |-> est_next_q == '0)
		else $error("Out-of-range channel carries a nonzero estimate.");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		wb_fire |=> out_valid_q && out_est_q == $past(est_next_q))
		else $error("Result register did not take the write-back value.");
`endif

endmodule

/* verif/skfb_estimate_checker.sv */
module skfb_estimate_checker #(
	parameter int CHANNELS = 3
) (
	input logic clk,
	input logic arst_n,
	skfb_in_if samples,
	skfb_out_if results,
	skfb_cfg_if cfg,
	output int errors,
	output int outstanding
);

	typedef struct packed {
		logic [skfb_pkg::CH_W-1:0] channel;
		logic signed [skfb_pkg::DATA_W-1:0] estimate;
	} filtered_t;

	logic [skfb_pkg::DATA_W-1:0] noise_q;
	logic [skfb_pkg::DATA_W-1:0] noise_r;
	logic signed [skfb_pkg::DATA_W-1:0] est_mem [CHANNELS];
	logic [skfb_pkg::DATA_W-1:0] cov_mem [CHANNELS];
	filtered_t estimates_due [$];
	int mismatch_count = 0;

	assign errors = mismatch_count;

	function automatic logic signed [skfb_pkg::DATA_W-1:0] kalman_update(
		input logic [skfb_pkg::CH_W-1:0] ch,
		input logic signed [skfb_pkg::DATA_W-1:0] measured
	);
		logic [skfb_pkg::DATA_W:0] prior_wide;
		logic [skfb_pkg::DATA_W-1:0] prior;
		logic [skfb_pkg::DATA_W:0] den;
		logic [63:0] quot;
		logic [skfb_pkg::GAIN_W-1:0] gain;
		logic [63:0] cov_wide;
		longint innov;
		longint correction;
		longint next_est;
		if (ch >= CHANNELS) begin
			return '0;
		end
		prior_wide = {1'b0, cov_mem[ch]} + {1'b0, noise_q};
		prior = prior_wide[skfb_pkg::DATA_W] ? '1 : prior_wide[skfb_pkg::DATA_W-1:0];
		den = {1'b0, prior} + {1'b0, noise_r};
		if (den == '0) begin
			gain = '0;
		end else begin
			quot = {16'b0, prior, 16'b0} / {31'b0, den};
			gain = (quot > 64'hFFFF) ? '1 : quot[skfb_pkg::GAIN_W-1:0];
		end
		innov = longint'(measured) - longint'(est_mem[ch]);
		correction = longint'({48'b0, gain}) * innov;
		next_est = longint'(est_mem[ch]) + (correction >>> 16);
		if (next_est > 64'sd2147483647) begin
			next_est = 64'sd2147483647;
		end else if (next_est < -64'sd2147483648) begin
			next_est = -64'sd2147483648;
		end
		cov_wide = ((64'd65536 - 64'(gain)) * 64'(prior)) >> 16;
		est_mem[ch] = next_est[skfb_pkg::DATA_W-1:0];
		cov_mem[ch] = (cov_wide > 64'hFFFF_FFFF) ? '1 : cov_wide[skfb_pkg::DATA_W-1:0];
		return next_est[skfb_pkg::DATA_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filtered_t due;
		filtered_t seen;
		if (!arst_n) begin
			noise_q = skfb_pkg::PROCESS_NOISE_RST;
			noise_r = skfb_pkg::MEASURE_NOISE_RST;
			for (int i = 0; i < CHANNELS; i++) begin
				est_mem[i] = '0;
				cov_mem[i] = '0;
			end
			estimates_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					skfb_pkg::CFG_PROCESS_NOISE: noise_q = cfg.data;
					skfb_pkg::CFG_MEASURE_NOISE: noise_r = cfg.data;
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				seen.channel = results.channel_out;
				seen.estimate = results.estimate;
				if (estimates_due.size() == 0) begin
					$display("%0t: unexpected transaction: channel %0d, estimate %0d",
						$time, seen.channel, seen.estimate);
					mismatch_count++;
				end else begin
					due = estimates_due.pop_front();
					if (seen.channel !== due.channel) begin
						$display("%0t: channel_out mismatch: expected %0d, actual %0d",
							$time, due.channel, seen.channel);
						mismatch_count++;
					end
					if (seen.estimate !== due.estimate) begin
						$display("%0t: estimate mismatch on channel %0d: expected %0d, actual %0d",
							$time, due.channel, due.estimate, seen.estimate);
						mismatch_count++;
					end
				end
			end
			if (samples.valid && samples.ready) begin
				due.channel = samples.channel;
				due.estimate = kalman_update(samples.channel, samples.sample);
				estimates_due.push_back(due);
			end
			outstanding <= estimates_due.size();
		end
	end

endmodule

/* verif/tb_top.sv */
module tb_top;

	localparam int CHANNELS = 3;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 250;
	localparam int SQUEEZE_PHASE = 3;
	localparam int SQUEEZE_CYCLES = 400;
	localparam int unsigned CYCLE_LIMIT = 1000000;

	logic clk = 1'b0;
	logic arst_n;
	int errors;
	int outstanding;
	bit squeeze_req = 1'b0;
	bit squeeze_done = 1'b0;
	logic signed [skfb_pkg::DATA_W-1:0] trend [4];

	skfb_in_if samples_if ();
	skfb_out_if results_if ();
	skfb_cfg_if cfg_if ();

	scalar_kalman_filter_bank_unit #(
		.CHANNELS(CHANNELS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg(cfg_if)
	);

	skfb_estimate_checker #(
		.CHANNELS(CHANNELS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples_if),
		.results(results_if),
		.cfg(cfg_if),
		.errors(errors),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	task automatic send_reading(input logic [skfb_pkg::CH_W-1:0] ch,
		input logic [skfb_pkg::DATA_W-1:0] value);
		samples_if.valid <= 1'b1;
		samples_if.channel <= ch;
		samples_if.sample <= value;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [skfb_pkg::CFG_IDX_W-1:0] idx,
		input logic [skfb_pkg::DATA_W-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_noise(input logic [skfb_pkg::DATA_W-1:0] q,
		input logic [skfb_pkg::DATA_W-1:0] r);
		wait_idle();
		write_reg(skfb_pkg::CFG_PROCESS_NOISE, q);
		write_reg(skfb_pkg::CFG_MEASURE_NOISE, r);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic logic [skfb_pkg::CH_W-1:0] pick_channel();
		return ($urandom_range(0, 15) == 0) ? skfb_pkg::CH_W'(3)
			: skfb_pkg::CH_W'($urandom_range(0, 2));
	endfunction

	// Two in five samples follow a slowly drifting signal per axis so the filters settle.
	function automatic logic [skfb_pkg::DATA_W-1:0] pick_sample(
		input logic [skfb_pkg::CH_W-1:0] ch);
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 3) begin
			return $urandom;
		end else if (roll < 4) begin
			case ($urandom_range(0, 4))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				3: return 32'hFFFF_FFFF;
				default: return 32'h0000_0001;
			endcase
		end else if (roll < 6) begin
			return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		end
		trend[ch] = trend[ch] + (32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
		return trend[ch] + (32'($urandom_range(0, 32'h0000_4000)) - 32'h0000_2000);
	endfunction

	initial begin : receiver
		int mode;
		int span;
		int tick;
		mode = 0;
		span = 0;
		tick = 0;
		results_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeeze_done) begin
				results_if.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
				squeeze_done = 1'b1;
				results_if.ready <= 1'b1;
			end else begin
				if (span == 0) begin
					mode = $urandom_range(0, 3);
					span = $urandom_range(8, 80);
				end
				span--;
				tick++;
				case (mode)
					0: results_if.ready <= 1'b1;
					1: results_if.ready <= 1'($urandom_range(0, 1));
					2: results_if.ready <= ($urandom_range(0, 3) == 0);
					default: results_if.ready <= (tick % 5 != 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin : stimulus
		logic [skfb_pkg::DATA_W-1:0] q;
		logic [skfb_pkg::DATA_W-1:0] r;
		int sent;
		int burst;
		int gap;
		arst_n = 1'b0;
		samples_if.valid = 1'b0;
		samples_if.channel = '0;
		samples_if.sample = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = skfb_pkg::CFG_PROCESS_NOISE;
		cfg_if.data = '0;
		gap = 0;
		for (int i = 0; i < 4; i++) begin
			trend[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With both noise terms zero and fresh state, the gain denominator is zero.
		set_noise(32'h0, 32'h0);
		send_reading(2'd0, 32'h7FFF_FFFF);
		send_reading(2'd3, 32'h1234_5678);
		samples_if.valid <= 1'b0;

		// Zero measurement noise drives the gain to its saturated value.
		set_noise(32'hFFFF_FFFF, 32'h0);
		send_reading(2'd0, 32'h7FFF_FFFF);
		send_reading(2'd1, 32'h8000_0000);
		send_reading(2'd2, 32'h8000_0000);
		send_reading(2'd2, 32'h7FFF_FFFF);
		send_reading(2'd3, 32'hFFFF_FFFF);
		samples_if.valid <= 1'b0;

		set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_reading(2'd0, 32'h8000_0000);
		send_reading(2'd1, 32'h7FFF_FFFF);
		send_reading(2'd2, 32'h0000_0000);
		send_reading(2'd0, 32'hFFFF_FFFF);
		samples_if.valid <= 1'b0;

		set_noise(skfb_pkg::PROCESS_NOISE_RST, skfb_pkg::MEASURE_NOISE_RST);
		send_reading(2'd0, $urandom);
		send_reading(2'd1, 32'h0000_0001);
		send_reading(2'd2, 32'hFFFF_FFFF);
		send_reading(2'd1, 32'h8000_0000);
		samples_if.valid <= 1'b0;

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					q = skfb_pkg::PROCESS_NOISE_RST;
					r = skfb_pkg::MEASURE_NOISE_RST;
				end
				1: begin q = $urandom_range(0, 32'hFFFF); r = $urandom_range(0, 32'h3FFFF); end
				2: begin q = 32'h0; r = 32'h0; end
				3: begin q = 32'hFFFF_FFFF; r = $urandom; end
				4: begin q = $urandom; r = 32'hFFFF_FFFF; end
				5: begin q = 32'h0; r = $urandom; end
				6: begin q = $urandom; r = $urandom; end
				default: begin q = 32'h1; r = 32'h1; end
			endcase
			set_noise(q, r);
			if (phase == SQUEEZE_PHASE) begin
				squeeze_req = 1'b1;
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = $urandom_range(1, 24);
				for (int k = 0; k < burst && sent < PHASE_ITEMS; k++) begin
					automatic logic [skfb_pkg::CH_W-1:0] ch = pick_channel();
					send_reading(ch, pick_sample(ch));
					sent++;
				end
				if (phase == SQUEEZE_PHASE || $urandom_range(0, 3) == 0) begin
					gap = 0;
				end else begin
					gap = $urandom_range(1, 12);
				end
				if (gap != 0) begin
					samples_if.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			samples_if.valid <= 1'b0;
		end

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
